[rtl/arld_pkg.sv]
// Shared widths and register codes of the attack/release level detector.
`timescale 1ns / 1ps

package arld_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEFF_BITS  = 16;
   localparam int STATE_BITS  = SAMPLE_BITS + COEFF_BITS;
   localparam int DIFF_BITS   = STATE_BITS + 1;
   localparam int CNT_BITS    = $clog2(COEFF_BITS);
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK_COEFF  = 2'd0,
      CSR_RELEASE_COEFF = 2'd1,
      CSR_DETECTOR_MODE = 2'd2
   } csr_index_type;

   localparam logic MODE_BRANCHED  = 1'b0;
   localparam logic MODE_DECOUPLED = 1'b1;

endpackage

[rtl/attack_release_level_detector.sv]
// Top level of the attack/release level detector with its serial multiplier.
//
// Each input word carries one signed sample on req_sample and yields one
// smoothed level on rsp_level. Both channels use valid and stall; a word moves
// at a clock edge where valid is high and stall is low. The coefficients and
// the detector mode are to be written through the csr_ port while the block
// is idle; the user must keep to this, the block itself does not enforce it.
// The blend of a sample towards the stored state multiplies the difference by
// the coefficient one coefficient bit per cycle; one blend is a set-up step,
// one shift-and-add step per coefficient bit and a finishing step. Branched
// mode needs one blend and decoupled mode needs two. A new sample is taken at
// the earliest in the cycle after the previous one has finished. The result
// register decouples the two sides: a new sample is accepted while a finished
// level still waits, and the block holds in its last step while the receiver
// stalls. Synchronous reset returns the block to idle in branched mode, clears
// the coefficients, the level and the peak to zero and drops rsp_valid.
`timescale 1ns / 1ps

module attack_release_level_detector
   import arld_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_level,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COEFF_BITS-1:0]         csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [COEFF_BITS-1:0]        attack_ff, attack_in;
   logic [COEFF_BITS-1:0]        release_ff, release_in;
   logic                         mode_ff, mode_in;
   logic signed [STATE_BITS-1:0] x_ff, x_in;
   logic signed [STATE_BITS-1:0] level_ff, level_in;
   logic signed [STATE_BITS-1:0] peak_ff, peak_in;
   logic signed [STATE_BITS-1:0] base_ff, base_in;
   logic signed [DIFF_BITS-1:0]  diff_ff, diff_in;
   logic signed [DIFF_BITS-1:0]  acc_ff, acc_in;
   logic [COEFF_BITS-1:0]        coeff_ff, coeff_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         pass_ff, pass_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_level_ff, rsp_level_in;

   logic                         req_accept;
   logic                         rsp_free;
   logic signed [DIFF_BITS:0]    step_sum;
   logic signed [DIFF_BITS-1:0]  addend;
   logic signed [STATE_BITS-1:0] blend_result;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_level  = rsp_level_ff;

   assign addend       = coeff_ff[0] ? diff_ff : '0;
   assign step_sum     = {acc_ff[DIFF_BITS-1], acc_ff} + {addend[DIFF_BITS-1], addend};
   assign blend_result = base_ff + acc_ff[STATE_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      mode_in      = mode_ff;
      x_in         = x_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      base_in      = base_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      coeff_in     = coeff_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_ATTACK_COEFF:  attack_in  = csr_data;
            CSR_RELEASE_COEFF: release_in = csr_data;
            CSR_DETECTOR_MODE: mode_in    = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in     = {req_sample, {COEFF_BITS{1'b0}}};
               pass_in  = 1'b0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            acc_in = '0;
            cnt_in = '0;
            if (mode_ff == MODE_BRANCHED) begin
               base_in  = x_ff;
               diff_in  = {level_ff[STATE_BITS-1], level_ff} - {x_ff[STATE_BITS-1], x_ff};
               coeff_in = (x_ff < level_ff) ? attack_ff : release_ff;
            end else if (!pass_ff) begin
               base_in  = x_ff;
               diff_in  = {peak_ff[STATE_BITS-1], peak_ff} - {x_ff[STATE_BITS-1], x_ff};
               coeff_in = release_ff;
            end else begin
               base_in  = peak_ff;
               diff_in  = {level_ff[STATE_BITS-1], level_ff}
                        - {peak_ff[STATE_BITS-1], peak_ff};
               coeff_in = attack_ff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in   = step_sum[DIFF_BITS:1];
            coeff_in = coeff_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(COEFF_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (mode_ff == MODE_DECOUPLED && !pass_ff) begin
               peak_in  = (x_ff > blend_result) ? x_ff : blend_result;
               pass_in  = 1'b1;
               state_in = ST_SETUP;
            end else if (rsp_free) begin
               level_in     = blend_result;
               rsp_valid_in = 1'b1;
               rsp_level_in = blend_result[STATE_BITS-1:COEFF_BITS];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         attack_ff    <= '0;
         release_ff   <= '0;
         mode_ff      <= MODE_BRANCHED;
         level_ff     <= '0;
         peak_ff      <= '0;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         mode_ff      <= mode_in;
         level_ff     <= level_in;
         peak_ff      <= peak_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      base_ff      <= base_in;
      diff_ff      <= diff_in;
      acc_ff       <= acc_in;
      coeff_ff     <= coeff_in;
      rsp_level_ff <= rsp_level_in;
   end

endmodule

[rtl/arld_checker.sv]
// Port-level checks on the attack/release level detector, bound to its top level.
`timescale 1ns / 1ps

module arld_checker
   import arld_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_level
);

   // After reset no result word is offered.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered straight after reset");

   // Once a sample is taken, the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second sample accepted while the first is being processed");

   // With no result word pending, a result never appears in the cycle after its sample is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result word appeared too early");

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_level)))
      else $error("stalled result word changed");

endmodule

bind attack_release_level_detector arld_checker u_arld_checker (.*);
